// ===== rtl/core/thws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thws_pkg: shared types and constants for the windowed history statistics
// Opcode codes and the fixed sample field width.
// ----------------------------------------------------------------------------
package thws_pkg;

  localparam int DATA_W = 32;

  typedef logic [1:0] opcode_t;

  localparam opcode_t OP_ADD = 2'd0;  // store a sample
  localparam opcode_t OP_AVG = 2'd1;  // windowed average query
  localparam opcode_t OP_MAX = 2'd2;  // windowed maximum query

endpackage

// ===== rtl/core/thws_ring.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thws_ring: sample ring storage
// One write port and one registered read port; entry is {time, duration}.
// ----------------------------------------------------------------------------
module thws_ring import thws_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_dur,
  input  logic [DATA_W-1:0] wr_ts,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_dur,
  output logic [DATA_W-1:0] rd_ts
);

  logic [2*DATA_W-1:0] mem [DEPTH];
  logic [2*DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_ts, wr_dur};
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_dur = rd_data_r[DATA_W-1:0];
  assign rd_ts  = rd_data_r[2*DATA_W-1:DATA_W];

endmodule

// ===== rtl/core/thws_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thws_divider: restoring serial divider
// One quotient bit per cycle through a shared compare/subtract; SUM_W steps.
// ----------------------------------------------------------------------------
module thws_divider import thws_pkg::*; #(
  parameter int SUM_W = 43,
  parameter int DIV_W = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [DIV_W-1:0]  divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] dvd_r, dvd_nxt;
  logic [DIV_W-1:0] div_r, div_nxt;
  logic [DIV_W-1:0] rem_r, rem_nxt;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = (trial >= {1'b0, div_r});

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(SUM_W);
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd_nxt = {dvd_r[SUM_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = dvd_r[DATA_W-1:0];

endmodule

// ===== rtl/core/timed_history_window_stats.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_history_window_stats: sliding time window average and maximum
// Ring of timestamped duration samples with windowed average/max queries.
// ----------------------------------------------------------------------------
//  channel | ports                                     | transfer
//  --------+-------------------------------------------+------------------------
//  input   | in_opcode, in_elapsed_us, in_timestamp_ms,| start & !busy
//          | in_window_ms                              |
//  result  | out_value_us                              | out_valid (one cycle)
//
//  Sequencing: an add never raises busy. A query walks the ring back from
//  the newest sample, one entry per cycle through the ring read port. A
//  maximum answers right after the walk; an average then runs the serial
//  divider. An empty ring answers next cycle.
//  Reset: synchronous, active low; clears the state, the newest-sample pointer
//  and the fill count; the ring storage itself is never cleared (entries are used only once written).
//  Stalls: the receiver cannot stall; a result is shown for one cycle only.
// ----------------------------------------------------------------------------
module timed_history_window_stats import thws_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_opcode,
  input  logic [DATA_W-1:0] in_elapsed_us,
  input  logic [DATA_W-1:0] in_timestamp_ms,
  input  logic [DATA_W-1:0] in_window_ms,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_value_us
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);   // fill count holds DEPTH itself
  localparam int SUM_W = DATA_W + CW;         // sum of up to DEPTH samples

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DIV  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [AW-1:0]     newest_r, newest_nxt;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;        // next slot to read during a walk
  logic [CW-1:0]     used_r, used_nxt;      // entries folded in so far
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [DATA_W-1:0] best_r, best_nxt;
  logic [DATA_W-1:0] first_ts_r, first_ts_nxt;
  logic [DATA_W-1:0] win_r, win_nxt;
  logic              want_max_r, want_max_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r, out_value_nxt;

  // ring ports
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_dur;
  logic [DATA_W-1:0] rd_ts;

  // divider ports
  logic              div_start;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;

  // walk datapath: one entry per cycle
  logic [DATA_W-1:0] ref_ts;
  logic [DATA_W-1:0] age;
  logic              last_entry;
  logic [SUM_W-1:0]  sum_add;
  logic [DATA_W-1:0] best_upd;
  logic [CW-1:0]     used_inc;

  function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] s);
    return (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
  endfunction

  // the newest entry's own time is the reference while it is being folded in
  assign ref_ts     = (used_r == '0) ? rd_ts : first_ts_r;
  assign age        = ref_ts - rd_ts;           // wraps modulo 2^32
  assign sum_add    = sum_r + SUM_W'(rd_dur);
  assign best_upd   = (rd_dur > best_r) ? rd_dur : best_r;
  assign used_inc   = used_r + CW'(1);
  assign last_entry = (age >= win_r) || (used_inc == fill_r);

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    newest_nxt    = newest_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    used_nxt      = used_r;
    sum_nxt       = sum_r;
    best_nxt      = best_r;
    first_ts_nxt  = first_ts_r;
    win_nxt       = win_r;
    want_max_nxt  = want_max_r;
    out_valid_nxt = 1'b0;
    out_value_nxt = out_value_r;
    wr_en         = 1'b0;
    wr_addr       = newest_r;
    rd_en         = 1'b0;
    rd_addr       = ptr_r;
    div_start     = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_opcode)
            OP_ADD: begin
              if (fill_r != CW'(DEPTH)) begin
                newest_nxt = fill_r[AW-1:0];
                fill_nxt   = fill_r + CW'(1);
              end else begin
                newest_nxt = (newest_r == AW'(DEPTH - 1)) ? '0 : newest_r + AW'(1);
              end
              wr_en   = 1'b1;
              wr_addr = newest_nxt;
            end
            OP_AVG, OP_MAX: begin
              want_max_nxt = (in_opcode == OP_MAX);
              win_nxt      = in_window_ms;
              if (fill_r == '0) begin
                out_valid_nxt = 1'b1;
                out_value_nxt = '0;
              end else begin
                // first read goes out now, data lands next cycle
                rd_en     = 1'b1;
                rd_addr   = newest_r;
                ptr_nxt   = slot_prev(newest_r);
                used_nxt  = '0;
                sum_nxt   = '0;
                best_nxt  = '0;
                state_nxt = S_WALK;
              end
            end
            default: begin
              // unused opcode: no state change, no result
            end
          endcase
        end
      end

      S_WALK: begin
        // keep a read in flight every cycle; reads past the stop are dropped
        rd_en        = 1'b1;
        rd_addr      = ptr_r;
        ptr_nxt      = slot_prev(ptr_r);
        first_ts_nxt = ref_ts;
        sum_nxt      = sum_add;
        best_nxt     = best_upd;
        used_nxt     = used_inc;
        if (last_entry) begin
          if (want_max_r) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = best_upd;
            state_nxt     = S_IDLE;
          end else begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = div_quot;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      newest_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // walk payload, no reset needed
  always_ff @(posedge clk) begin
    ptr_r       <= ptr_nxt;
    used_r      <= used_nxt;
    sum_r       <= sum_nxt;
    best_r      <= best_nxt;
    first_ts_r  <= first_ts_nxt;
    win_r       <= win_nxt;
    want_max_r  <= want_max_nxt;
    out_value_r <= out_value_nxt;
  end

  thws_ring #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_dur  (in_elapsed_us),
    .wr_ts   (in_timestamp_ms),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_dur  (rd_dur),
    .rd_ts   (rd_ts)
  );

  // sum and count of the final walk cycle feed the divider directly
  thws_divider #(
    .SUM_W (SUM_W),
    .DIV_W (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_add),
    .divisor  (used_inc),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign out_valid    = out_valid_r;
  assign out_value_us = out_value_r;

endmodule
